### sv/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg: shared types and constants of the BMP pixel to BGRA converter
// Channel layout, register indexes, command codes, pixel modes and the
// sizes of the queue and divider pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // Channel order inside an item
    localparam int NUM_CH    = 4;
    localparam int CH_BLUE   = 0;
    localparam int CH_GREEN  = 1;
    localparam int CH_RED    = 2;
    localparam int CH_ALPHA  = 3;

    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int PAL_W     = 24;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_MODE   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RED_MASK     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GREEN_MASK   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BLUE_MASK    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_MASK   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_ENABLE = 3'd5;

    // Input commands
    localparam logic CMD_CONVERT       = 1'b0;
    localparam logic CMD_PALETTE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        MODE_PALETTE   = 2'd0,
        MODE_BGR24     = 2'd1,
        MODE_BGRX32    = 2'd2,
        MODE_BITFIELDS = 2'd3
    } mode_t;

    // Denominator 2^8 - 1: with it a byte value passes the rescale unchanged
    localparam logic [WORD_W-1:0] DEN_BYTE = 32'd255;

    // Front to back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QCNT_W:0] QUEUE_FULL = (QCNT_W + 1)'(QUEUE_DEPTH);

    // Rescale divider: 8 quotient bits, numerator 510*v + D < 2^41
    localparam int QUOT_W = BYTE_W;
    localparam int REM_W  = WORD_W + 9;
    localparam int DIV_W  = WORD_W + 1;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] denom;
    } chan_t;

    typedef chan_t [NUM_CH-1:0] item_t;

endpackage

### sv/bmp_pixel_to_bgra_converter.sv
// ----------------------------------------------------------------------------
// bmp_pixel_to_bgra_converter: BMP source pixel to BGRA8888
// Converts palette, 24-bit BGR, 32-bit BGRx and 32-bit bitfields pixels.
// ----------------------------------------------------------------------------
// While neither side stalls, the block takes one item per clock and delivers
// one BGRA result per clock for a steady stream of convert items; a palette
// write is absorbed without a result. An item passes through the palette read
// and classify stage, the queue and the rescale pipeline, whose eight stages
// each settle one quotient bit of round(v*255/D) for all four channels at
// once, the last stage being the output register. The palette is a 256-entry
// RAM whose entries read as black until written, tracked by one valid bit per
// entry, so no clearing pass is needed after reset. Configuration must be
// written only while no item is in flight. Input stall depends only on queue
// occupancy and the classify stage, never on out_stall directly, so the two
// channels stall independently.
// ----------------------------------------------------------------------------
module bmp_pixel_to_bgra_converter #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // configuration
    input  logic                              cfg_write,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]    cfg_data,

    // input items
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              command,
    input  logic [bpc_pkg::WORD_W-1:0]        source_word,
    input  logic [7:0]                        palette_index,

    // result items
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bpc_pkg::BYTE_W-1:0]        blue,
    output logic [bpc_pkg::BYTE_W-1:0]        green,
    output logic [bpc_pkg::BYTE_W-1:0]        red,
    output logic [bpc_pkg::BYTE_W-1:0]        alpha
);

    logic                              q_push;
    logic                              q_pop;
    bpc_pkg::item_t                    q_item;
    bpc_pkg::item_t                    head_item;
    logic [bpc_pkg::QCNT_W-1:0]        q_count;

    // Front: configuration, palette, classify into channel pairs
    bpc_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .source_word   (source_word),
        .palette_index (palette_index),
        .q_count       (q_count),
        .q_push        (q_push),
        .q_item        (q_item)
    );

    // Queue: decouple classify from the rescale pipeline
    bpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head_item (head_item),
        .count     (q_count)
    );

    // Back: rescale every channel and hold the result until transferred
    bpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (head_item),
        .q_count   (q_count),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .alpha     (alpha)
    );

    // Queue never holds more than its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= bpc_pkg::QCNT_W'(bpc_pkg::QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    // Push only into a queue with room, since stall counts the classify stage
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < bpc_pkg::QCNT_W'(bpc_pkg::QUEUE_DEPTH)))
        else $error("push into full queue");

    // A convert transfer enters the queue on the next cycle
    a_convert_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (command == bpc_pkg::CMD_CONVERT)) |=> q_push)
        else $error("convert item lost before queue");

    // A palette write transfer never produces a queue entry
    a_write_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (command == bpc_pkg::CMD_PALETTE_WRITE)) |=> !q_push)
        else $error("palette write produced a result");

endmodule

### sv/bpc_ram.sv
// ----------------------------------------------------------------------------
// bpc_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bpc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/bpc_front.sv
// ----------------------------------------------------------------------------
// bpc_front: input side of the converter
// Holds the configuration, the palette and its valid bits, accepts items,
// and turns each convert item into four (value, denominator) channel pairs.
// ----------------------------------------------------------------------------
module bpc_front #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [bpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [bpc_pkg::WORD_W-1:0]          source_word,
    input  logic [7:0]                          palette_index,
    input  logic [bpc_pkg::QCNT_W-1:0]          q_count,
    output logic                                q_push,
    output bpc_pkg::item_t                      q_item
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

    function automatic logic [4:0] lowest_set(input logic [bpc_pkg::WORD_W-1:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = bpc_pkg::WORD_W - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

    function automatic logic [4:0] highest_set(input logic [bpc_pkg::WORD_W-1:0] m);
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < bpc_pkg::WORD_W; i++)
        begin
            if (m[i])
            begin
                n = 5'(i);
            end
        end
        return n;
    endfunction

    // Configuration
    bpc_pkg::mode_t              mode_reg;
    logic [bpc_pkg::WORD_W-1:0]  mask_reg [bpc_pkg::NUM_CH];
    logic                        alpha_en_reg;

    // Mask geometry, refreshed every cycle from the masks
    logic [4:0]                  lo_reg   [bpc_pkg::NUM_CH];
    logic [bpc_pkg::WORD_W-1:0]  den_reg  [bpc_pkg::NUM_CH];
    logic [bpc_pkg::NUM_CH-1:0]  nz_reg;

    // Palette
    logic [PALETTE_ENTRIES-1:0]  pal_valid_reg;
    logic [bpc_pkg::PAL_W-1:0]   pal_rdata;
    logic                        pal_we;

    // Classify stage
    logic                        s1_valid_reg;
    logic                        s1_valid_next;
    logic [bpc_pkg::WORD_W-1:0]  s1_word_reg;
    logic                        s1_hit_reg;
    logic                        s1_hit_next;

    logic                        accept;
    logic [bpc_pkg::QCNT_W:0]    fill;
    logic [bpc_pkg::PAL_W-1:0]   entry;

    assign fill     = {1'b0, q_count} + {{bpc_pkg::QCNT_W{1'b0}}, s1_valid_reg};
    assign in_stall = (fill >= bpc_pkg::QUEUE_FULL);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= bpc_pkg::MODE_PALETTE;
            alpha_en_reg <= 1'b0;
            for (int c = 0; c < bpc_pkg::NUM_CH; c++)
            begin
                mask_reg[c] <= '0;
            end
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bpc_pkg::REG_PIXEL_MODE:   mode_reg <= bpc_pkg::mode_t'(cfg_data[1:0]);
                bpc_pkg::REG_RED_MASK:     mask_reg[bpc_pkg::CH_RED]   <= cfg_data;
                bpc_pkg::REG_GREEN_MASK:   mask_reg[bpc_pkg::CH_GREEN] <= cfg_data;
                bpc_pkg::REG_BLUE_MASK:    mask_reg[bpc_pkg::CH_BLUE]  <= cfg_data;
                bpc_pkg::REG_ALPHA_MASK:   mask_reg[bpc_pkg::CH_ALPHA] <= cfg_data;
                bpc_pkg::REG_ALPHA_ENABLE: alpha_en_reg <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg <= '0;
            for (int c = 0; c < bpc_pkg::NUM_CH; c++)
            begin
                lo_reg[c]  <= '0;
                den_reg[c] <= bpc_pkg::DEN_BYTE;
            end
        end
        else
        begin
            for (int c = 0; c < bpc_pkg::NUM_CH; c++)
            begin
                nz_reg[c]  <= (mask_reg[c] != '0);
                lo_reg[c]  <= lowest_set(mask_reg[c]);
                // all ones over the span from lowest to highest mask bit
                den_reg[c] <= 32'hFFFF_FFFF >>
                    (5'd31 - (highest_set(mask_reg[c]) - lowest_set(mask_reg[c])));
            end
        end
    end

    // Write the palette at accept; drop writes beyond the table
    assign pal_we = accept && (command == bpc_pkg::CMD_PALETTE_WRITE) &&
                    ({1'b0, palette_index} < PAL_LIMIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_valid_reg <= '0;
        end
        else if (pal_we)
        begin
            pal_valid_reg[palette_index[AW-1:0]] <= 1'b1;
        end
    end

    bpc_ram #(
        .WIDTH (bpc_pkg::PAL_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (palette_index[AW-1:0]),
        .wdata (source_word[bpc_pkg::PAL_W-1:0]),
        .re    (accept),
        .raddr (source_word[AW-1:0]),
        .rdata (pal_rdata)
    );

    assign s1_valid_next = accept && (command == bpc_pkg::CMD_CONVERT);
    assign s1_hit_next   = ({1'b0, source_word[7:0]} < PAL_LIMIT) &&
                           pal_valid_reg[source_word[AW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_word_reg <= source_word;
            s1_hit_reg  <= s1_hit_next;
        end
    end

    // An item in the classify stage always moves into the queue next cycle
    assign q_push = s1_valid_reg;
    assign entry  = s1_hit_reg ? pal_rdata : '0;

    always_comb
    begin
        for (int c = 0; c < bpc_pkg::NUM_CH; c++)
        begin
            q_item[c].value = '0;
            q_item[c].denom = bpc_pkg::DEN_BYTE;
        end
        q_item[bpc_pkg::CH_ALPHA].value = bpc_pkg::DEN_BYTE;
        case (mode_reg)
            bpc_pkg::MODE_PALETTE:
            begin
                q_item[bpc_pkg::CH_BLUE].value  = 32'(entry[7:0]);
                q_item[bpc_pkg::CH_GREEN].value = 32'(entry[15:8]);
                q_item[bpc_pkg::CH_RED].value   = 32'(entry[23:16]);
            end
            bpc_pkg::MODE_BGR24, bpc_pkg::MODE_BGRX32:
            begin
                q_item[bpc_pkg::CH_BLUE].value  = 32'(s1_word_reg[7:0]);
                q_item[bpc_pkg::CH_GREEN].value = 32'(s1_word_reg[15:8]);
                q_item[bpc_pkg::CH_RED].value   = 32'(s1_word_reg[23:16]);
            end
            bpc_pkg::MODE_BITFIELDS:
            begin
                for (int c = 0; c < bpc_pkg::NUM_CH; c++)
                begin
                    if (nz_reg[c] && ((c != bpc_pkg::CH_ALPHA) || alpha_en_reg))
                    begin
                        q_item[c].value = (s1_word_reg & mask_reg[c]) >> lo_reg[c];
                        q_item[c].denom = den_reg[c];
                    end
                end
            end
            default:
            begin
                q_item[bpc_pkg::CH_BLUE].value = '0;
            end
        endcase
    end

endmodule

### sv/bpc_queue.sv
// ----------------------------------------------------------------------------
// bpc_queue: short queue between classify and rescale
// Register-based FIFO; head entry is presented while count is nonzero.
// ----------------------------------------------------------------------------
module bpc_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  bpc_pkg::item_t              push_item,
    input  logic                        pop,
    output bpc_pkg::item_t              head_item,
    output logic [bpc_pkg::QCNT_W-1:0]  count
);

    bpc_pkg::item_t                  data_reg [bpc_pkg::QUEUE_DEPTH];
    logic [bpc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [bpc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [bpc_pkg::QCNT_W-1:0]      count_reg;
    logic [bpc_pkg::QCNT_W-1:0]      count_next;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_item = data_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

### sv/bpc_back.sv
// ----------------------------------------------------------------------------
// bpc_back: rescale pipeline and output register
// Computes round(v*255/D) as floor((510v + D) / 2D) for four channels with
// a restoring divider, one quotient bit per stage, last stage is the output.
// ----------------------------------------------------------------------------
module bpc_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bpc_pkg::item_t                    head_item,
    input  logic [bpc_pkg::QCNT_W-1:0]        q_count,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bpc_pkg::BYTE_W-1:0]        blue,
    output logic [bpc_pkg::BYTE_W-1:0]        green,
    output logic [bpc_pkg::BYTE_W-1:0]        red,
    output logic [bpc_pkg::BYTE_W-1:0]        alpha
);

    localparam int LAST = bpc_pkg::QUOT_W;

    logic [LAST:0]                   valid_reg;
    logic [LAST:0]                   adv;

    logic [bpc_pkg::REM_W-1:0]   rem_reg  [LAST][bpc_pkg::NUM_CH];
    logic [bpc_pkg::DIV_W-1:0]   div_reg  [LAST][bpc_pkg::NUM_CH];
    logic [bpc_pkg::QUOT_W-1:0]  quot_reg [1:LAST][bpc_pkg::NUM_CH];

    // Advance a stage when it is empty or the one after it advances
    assign adv[LAST] = !valid_reg[LAST] || !out_stall;
    for (genvar s = 0; s < LAST; s++)
    begin : g_adv
        assign adv[s] = !valid_reg[s] || adv[s + 1];
    end

    assign q_pop = (q_count != '0) && adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                valid_reg[0] <= q_pop;
            end
            for (int s = 1; s <= LAST; s++)
            begin
                if (adv[s])
                begin
                    valid_reg[s] <= valid_reg[s - 1];
                end
            end
        end
    end

    // Prepare numerator and doubled divisor
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int c = 0; c < bpc_pkg::NUM_CH; c++)
            begin
                rem_reg[0][c] <= (bpc_pkg::REM_W'(head_item[c].value) << 9)
                               - (bpc_pkg::REM_W'(head_item[c].value) << 1)
                               + bpc_pkg::REM_W'(head_item[c].denom);
                div_reg[0][c] <= {head_item[c].denom, 1'b0};
            end
        end
    end

    // Stage j settles quotient bit QUOT_W - j
    for (genvar j = 1; j <= LAST; j++)
    begin : g_step
        localparam int K = LAST - j;

        logic [bpc_pkg::REM_W-1:0]  trial  [bpc_pkg::NUM_CH];
        logic [bpc_pkg::NUM_CH-1:0] fits;
        logic [bpc_pkg::QUOT_W-1:0] prev_q [bpc_pkg::NUM_CH];

        always_comb
        begin
            for (int c = 0; c < bpc_pkg::NUM_CH; c++)
            begin
                trial[c] = bpc_pkg::REM_W'(div_reg[j - 1][c]) << K;
                fits[c]  = (rem_reg[j - 1][c] >= trial[c]);
            end
        end

        if (j == 1)
        begin : g_first
            always_comb
            begin
                for (int c = 0; c < bpc_pkg::NUM_CH; c++)
                begin
                    prev_q[c] = '0;
                end
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                for (int c = 0; c < bpc_pkg::NUM_CH; c++)
                begin
                    prev_q[c] = quot_reg[j - 1][c];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[j] && valid_reg[j - 1])
            begin
                for (int c = 0; c < bpc_pkg::NUM_CH; c++)
                begin
                    quot_reg[j][c] <= {prev_q[c][bpc_pkg::QUOT_W-2:0], fits[c]};
                end
            end
        end

        if (j < LAST)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv[j] && valid_reg[j - 1])
                begin
                    for (int c = 0; c < bpc_pkg::NUM_CH; c++)
                    begin
                        rem_reg[j][c] <= fits[c] ? (rem_reg[j - 1][c] - trial[c])
                                                 : rem_reg[j - 1][c];
                        div_reg[j][c] <= div_reg[j - 1][c];
                    end
                end
            end
        end
    end

    assign out_valid = valid_reg[LAST];
    assign blue      = quot_reg[LAST][bpc_pkg::CH_BLUE];
    assign green     = quot_reg[LAST][bpc_pkg::CH_GREEN];
    assign red       = quot_reg[LAST][bpc_pkg::CH_RED];
    assign alpha     = quot_reg[LAST][bpc_pkg::CH_ALPHA];

endmodule
